@@ design/gda_pkg.sv @@
// Shared constants and calendar helper functions for the Gregorian date unit.
// Used by gda_pipe_ctrl and gregorian_date_arithmetic; depends on nothing.
package gda_pkg;

    localparam int GDA_STAGES = 8;

    localparam logic        KIND_ADD    = 1'b0;
    localparam logic        KIND_DIFF   = 1'b1;

    localparam logic [3:0]  MONTH_FEB   = 4'd2;
    localparam logic [3:0]  MONTH_DEC   = 4'd12;
    localparam logic [13:0] YEAR_MAX    = 14'd9999;
    localparam logic [4:0]  DAY_MAX     = 5'd31;
    localparam logic [23:0] DAYS_400Y   = 24'd146097;
    localparam logic [31:0] RECIP_400Y  = 32'd459;     // 2^26 / 146097, rounded down
    localparam logic [36:0] RECIP_366   = 37'd366716;  // 2^27 / 366, rounded up

    // floor(v / 25) for v < 43690
    function automatic logic [8:0] div25(input logic [12:0] v);
        logic [25:0] p;
        p = 26'(v) * 26'd5243;
        return p[25:17];
    endfunction

    // Days in years 0 .. y-1, proleptic Gregorian
    function automatic logic [22:0] days_before_year(input logic [13:0] y);
        logic [14:0] y3;
        logic [14:0] y99;
        logic [14:0] y399;
        logic [22:0] sum;
        y3   = 15'(y) + 15'd3;
        y99  = 15'(y) + 15'd99;
        y399 = 15'(y) + 15'd399;
        sum  = 23'(y) * 23'd365 + 23'(y3[14:2])
             - 23'(div25(y99[14:2])) + 23'(div25({2'b00, y399[14:4]}));
        return sum;
    endfunction

    function automatic logic is_leap(input logic [13:0] y);
        logic [8:0] h;
        logic       cent;
        h    = div25(y[13:1] >> 1);
        cent = (y == 14'(14'(h) * 14'd100));
        return cent ? (h[1:0] == 2'd0) : (y[1:0] == 2'd0);
    endfunction

    // Days before the first of month m in a common year; 0 for bad months
    function automatic logic [8:0] cum_days(input logic [3:0] m);
        logic [8:0] c;
        unique case (m)
            4'd1:    c = 9'd0;
            4'd2:    c = 9'd31;
            4'd3:    c = 9'd59;
            4'd4:    c = 9'd90;
            4'd5:    c = 9'd120;
            4'd6:    c = 9'd151;
            4'd7:    c = 9'd181;
            4'd8:    c = 9'd212;
            4'd9:    c = 9'd243;
            4'd10:   c = 9'd273;
            4'd11:   c = 9'd304;
            4'd12:   c = 9'd334;
            default: c = 9'd0;
        endcase
        return c;
    endfunction

    function automatic logic month_ok(input logic [3:0] m);
        return (m != 4'd0) && (m <= MONTH_DEC);
    endfunction

endpackage

@@ design/gda_pipe_ctrl.sv @@
// Valid/advance control for the date pipeline: one valid bit per stage,
// bubbles collapse, a stall holds each occupied stage with no empty stage ahead. Uses gda_pkg.
module gda_pipe_ctrl
    import gda_pkg::*;
#(
    parameter int STAGES = GDA_STAGES
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic              out_ready,
    output logic              in_ready,
    output logic [STAGES-1:0] load,
    output logic              out_valid
);

    logic [STAGES-1:0] valid_reg;
    logic [STAGES-1:0] valid_next;
    logic [STAGES:0]   adv;

    always_comb
    begin
        adv[STAGES] = out_ready;
        for (int k = STAGES - 1; k >= 0; k--)
        begin
            adv[k] = !valid_reg[k] || adv[k+1];
        end
        for (int k = 0; k < STAGES; k++)
        begin
            if (adv[k])
            begin
                valid_next[k] = (k == 0) ? in_valid : valid_reg[(k == 0) ? 0 : k - 1];
            end
            else
            begin
                valid_next[k] = valid_reg[k];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    assign load      = adv[STAGES-1:0];
    assign in_ready  = adv[0];
    assign out_valid = valid_reg[STAGES-1];

endmodule

@@ design/gregorian_date_arithmetic.sv @@
// Gregorian date unit: add days to a date, or signed day difference of two dates.
// One item per cycle sustained while out_ready stays high, through the
// 8-stage datapath (year-block split, year search, month search).
// A stalled output holds only the occupied stages; empty stages keep accepting.
// rst_n (async, active low) clears all stage valid bits; no other state.
// Depends on gda_pkg and gda_pipe_ctrl.
module gregorian_date_arithmetic
    import gda_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               kind,
    input  logic [4:0]         day_a,
    input  logic [3:0]         month_a,
    input  logic [13:0]        year_a,
    input  logic [4:0]         day_b,
    input  logic [3:0]         month_b,
    input  logic [13:0]        year_b,
    input  logic [19:0]        add_count,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [4:0]         day_out,
    output logic [3:0]         month_out,
    output logic [13:0]        year_out,
    output logic signed [22:0] day_difference,
    output logic               a_after_b,
    output logic               a_before_b,
    output logic               dates_valid,
    output logic               year_overflow
);

    typedef struct packed {
        logic               kind;
        logic [4:0]         da;
        logic [3:0]         ma;
        logic [13:0]        ya;
        logic [4:0]         db;
        logic [3:0]         mb;
        logic [19:0]        cnt;
        logic               va;
        logic               vb;
        logic [22:0]        dbya;
        logic [22:0]        dbyb;
        logic               lpa;
        logic               lpb;
        logic [22:0]        oa;
        logic [22:0]        ob;
        logic [22:0]        n;
        logic               zero;
        logic signed [22:0] diff;
        logic               after;
        logic               earlier;
        logic [5:0]         q;
        logic [17:0]        r;
        logic [8:0]         ylo;
        logic [17:0]        d0;
        logic [17:0]        d1;
        logic [17:0]        d2;
        logic               l0;
        logic               l1;
        logic               l2;
        logic [8:0]         yc;
        logic [8:0]         doy;
        logic               lsel;
    } stage_t;

    logic [GDA_STAGES-1:0] load;

    stage_t s1_reg, s2_reg, s3_reg, s4_reg, s5_reg, s6_reg, s7_reg;
    stage_t s1_next, s2_next, s3_next, s4_next, s5_next, s6_next, s7_next;

    logic [4:0]         day_reg, day_next;
    logic [3:0]         month_reg, month_next;
    logic [13:0]        year_reg, year_next;
    logic signed [22:0] diff_reg, diff_next;
    logic               after_reg, after_next;
    logic               before_reg, before_next;
    logic               valid_reg, valid_next;
    logic               ovf_reg, ovf_next;

    gda_pipe_ctrl #(
        .STAGES (GDA_STAGES)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .out_ready (out_ready),
        .in_ready  (in_ready),
        .load      (load),
        .out_valid (out_valid)
    );

    // stage 1: year day counts and leap flags
    always_comb
    begin
        s1_next      = '0;
        s1_next.kind = kind;
        s1_next.da   = day_a;
        s1_next.ma   = month_a;
        s1_next.ya   = year_a;
        s1_next.db   = day_b;
        s1_next.mb   = month_b;
        s1_next.cnt  = add_count;
        s1_next.va   = month_ok(month_a);
        s1_next.vb   = month_ok(month_b);
        s1_next.dbya = days_before_year(year_a);
        s1_next.dbyb = days_before_year(year_b);
        s1_next.lpa  = is_leap(year_a);
        s1_next.lpb  = is_leap(year_b);
    end

    // stage 2: ordinal day numbers
    always_comb
    begin
        s2_next      = s1_reg;
        s2_next.oa   = s1_reg.dbya + 23'(cum_days(s1_reg.ma)) + 23'(s1_reg.da)
                     + 23'((s1_reg.ma > MONTH_FEB) && s1_reg.lpa);
        s2_next.ob   = s1_reg.dbyb + 23'(cum_days(s1_reg.mb)) + 23'(s1_reg.db)
                     + 23'((s1_reg.mb > MONTH_FEB) && s1_reg.lpb);
        s2_next.n    = s2_next.oa + 23'(s1_reg.cnt) - 23'd1;
        s2_next.zero = (s1_reg.da == 5'd0) && (s1_reg.cnt == 20'd0);
    end

    // stage 3: difference for compares, 400-year block estimate for sums
    always_comb
    begin
        logic signed [23:0] dfull;
        logic [31:0]        qp;
        s3_next = s2_reg;
        dfull   = $signed({1'b0, s2_reg.oa}) - $signed({1'b0, s2_reg.ob});
        qp      = 32'(s2_reg.n) * RECIP_400Y;
        s3_next.q       = qp[31:26];
        s3_next.diff    = '0;
        s3_next.after   = 1'b0;
        s3_next.earlier = 1'b0;
        if ((s2_reg.kind == KIND_DIFF) && s2_reg.va && s2_reg.vb)
        begin
            s3_next.after   = (dfull > 24'sd0);
            s3_next.earlier = (dfull < 24'sd0);
            if (dfull > 24'sd4194303)
            begin
                s3_next.diff = 23'sh3FFFFF;
            end
            else if (dfull < -24'sd4194304)
            begin
                s3_next.diff = 23'sh400000;
            end
            else
            begin
                s3_next.diff = dfull[22:0];
            end
        end
    end

    // stage 4: remainder within the 400-year block, one correction step
    always_comb
    begin
        logic [23:0] r0;
        s4_next = s3_reg;
        r0      = {1'b0, s3_reg.n} - 24'(s3_reg.q) * DAYS_400Y;
        if (r0 >= DAYS_400Y)
        begin
            s4_next.r = 18'(r0 - DAYS_400Y);
            s4_next.q = s3_reg.q + 6'd1;
        end
        else
        begin
            s4_next.r = r0[17:0];
        end
    end

    // stage 5: lower bound of the year in the block
    always_comb
    begin
        logic [36:0] yp;
        s5_next     = s4_reg;
        yp          = 37'(s4_reg.r) * RECIP_366;
        s5_next.ylo = yp[35:27];
    end

    // stage 6: day counts for the three candidate years
    always_comb
    begin
        logic [22:0] t0, t1, t2;
        s6_next = s5_reg;
        t0 = days_before_year(14'(s5_reg.ylo));
        t1 = days_before_year(14'(s5_reg.ylo) + 14'd1);
        t2 = days_before_year(14'(s5_reg.ylo) + 14'd2);
        s6_next.d0 = t0[17:0];
        s6_next.d1 = t1[17:0];
        s6_next.d2 = t2[17:0];
        s6_next.l0 = is_leap(14'(s5_reg.ylo));
        s6_next.l1 = is_leap(14'(s5_reg.ylo) + 14'd1);
        s6_next.l2 = is_leap(14'(s5_reg.ylo) + 14'd2);
    end

    // stage 7: pick the year, day of year
    always_comb
    begin
        logic [17:0] dsel;
        s7_next = s6_reg;
        priority if (s6_reg.d2 <= s6_reg.r)
        begin
            s7_next.yc   = s6_reg.ylo + 9'd2;
            s7_next.lsel = s6_reg.l2;
            dsel         = s6_reg.d2;
        end
        else if (s6_reg.d1 <= s6_reg.r)
        begin
            s7_next.yc   = s6_reg.ylo + 9'd1;
            s7_next.lsel = s6_reg.l1;
            dsel         = s6_reg.d1;
        end
        else
        begin
            s7_next.yc   = s6_reg.ylo;
            s7_next.lsel = s6_reg.l0;
            dsel         = s6_reg.d0;
        end
        s7_next.doy = 9'(s6_reg.r - dsel);
    end

    // stage 8: month search, final selection and saturation
    always_comb
    begin
        logic [3:0]  mo;
        logic [8:0]  cl;
        logic [8:0]  csel;
        logic [14:0] yfull;
        mo   = 4'd1;
        csel = 9'd0;
        for (int m = 2; m <= 12; m++)
        begin
            cl = cum_days(4'(m)) + 9'((m > 2) && s7_reg.lsel);
            if (cl <= s7_reg.doy)
            begin
                mo   = 4'(m);
                csel = cl;
            end
        end
        yfull = 15'(s7_reg.yc) + 15'(s7_reg.q) * 15'd400;

        day_next    = '0;
        month_next  = '0;
        year_next   = '0;
        ovf_next    = 1'b0;
        diff_next   = s7_reg.diff;
        after_next  = s7_reg.after;
        before_next = s7_reg.earlier;
        if (s7_reg.kind == KIND_ADD)
        begin
            valid_next = s7_reg.va;
            if (!s7_reg.va)
            begin
                day_next   = s7_reg.da;
                month_next = s7_reg.ma;
                year_next  = s7_reg.ya;
            end
            else
            begin
                if (s7_reg.zero)
                begin
                    day_next   = 5'd0;
                    month_next = s7_reg.ma;
                    yfull      = 15'(s7_reg.ya);
                end
                else
                begin
                    day_next   = 5'(s7_reg.doy - csel + 9'd1);
                    month_next = mo;
                end
                if (yfull > 15'(YEAR_MAX))
                begin
                    day_next   = DAY_MAX;
                    month_next = MONTH_DEC;
                    year_next  = YEAR_MAX;
                    ovf_next   = 1'b1;
                end
                else
                begin
                    year_next = yfull[13:0];
                end
            end
        end
        else
        begin
            valid_next = s7_reg.va && s7_reg.vb;
        end
    end

    // payload registers; valid bits live in the control block
    always_ff @(posedge clk)
    begin
        if (load[0]) s1_reg <= s1_next;
        if (load[1]) s2_reg <= s2_next;
        if (load[2]) s3_reg <= s3_next;
        if (load[3]) s4_reg <= s4_next;
        if (load[4]) s5_reg <= s5_next;
        if (load[5]) s6_reg <= s6_next;
        if (load[6]) s7_reg <= s7_next;
        if (load[7])
        begin
            day_reg    <= day_next;
            month_reg  <= month_next;
            year_reg   <= year_next;
            diff_reg   <= diff_next;
            after_reg  <= after_next;
            before_reg <= before_next;
            valid_reg  <= valid_next;
            ovf_reg    <= ovf_next;
        end
    end

    assign day_out        = day_reg;
    assign month_out      = month_reg;
    assign year_out       = year_reg;
    assign day_difference = diff_reg;
    assign a_after_b      = after_reg;
    assign a_before_b     = before_reg;
    assign dates_valid    = valid_reg;
    assign year_overflow  = ovf_reg;

    // an empty output stage means the whole pipe can advance
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled with empty output stage");

    a_sign_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(a_after_b && a_before_b))
        else $error("after and before both set");

    a_ovf_saturates: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && year_overflow |->
            (year_out == YEAR_MAX) && (month_out == MONTH_DEC) && (day_out == DAY_MAX))
        else $error("overflow without saturated date");

    a_invalid_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !dates_valid |->
            !a_after_b && !a_before_b && !year_overflow && (day_difference == 23'sd0))
        else $error("invalid dates produced flags");

endmodule

@@ tb/tb_top.sv @@
// Self-checking testbench for gregorian_date_arithmetic: date add and day difference.
// Predicts each result with a local calendar model; depends on gda_pkg and the RTL.
module tb_top
    import gda_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int IDLE_LIMIT = 20000;

    typedef struct packed {
        logic [4:0]         day;
        logic [3:0]         month;
        logic [13:0]        year;
        logic signed [22:0] diff;
        logic               after;
        logic               earlier;
        logic               valid;
        logic               ovf;
    } date_result_t;

    logic clk, rst_n;
    logic in_valid, in_ready, out_valid, out_ready;
    logic kind;
    logic [4:0] day_a, day_b;
    logic [3:0] month_a, month_b;
    logic [13:0] year_a, year_b;
    logic [19:0] add_count;
    logic [4:0] day_out;
    logic [3:0] month_out;
    logic [13:0] year_out;
    logic signed [22:0] day_difference;
    logic a_after_b, a_before_b, dates_valid, year_overflow;

    date_result_t expected_dates[$];
    int errors = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    bit hold_off = 0;
    int idle_cycles = 0;

    gregorian_date_arithmetic dut (.*);

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    function automatic bit leap_year(longint y);
        return (y % 4 == 0 && y % 100 != 0) || (y % 400 == 0);
    endfunction

    function automatic longint days_to_year(longint y);
        return 365 * y + (y + 3) / 4 - (y + 99) / 100 + (y + 399) / 400;
    endfunction

    function automatic longint month_length(longint m, longint y);
        longint lens[12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
        if (m == 2 && leap_year(y))
            return 29;
        return lens[m - 1];
    endfunction

    function automatic longint day_number(longint d, longint m, longint y);
        longint cum[12] = '{0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334};
        longint n;
        n = days_to_year(y) + cum[m - 1] + d - 1;
        if (m > 2 && leap_year(y))
            n += 1;
        return n;
    endfunction

    function automatic date_result_t predict_date(logic k, logic [4:0] da, logic [3:0] ma,
        logic [13:0] ya, logic [4:0] db, logic [3:0] mb, logic [13:0] yb, logic [19:0] cnt);
        date_result_t r;
        bit va, vb;
        longint n, q, rem, y, doy, m, dd, d;
        r = '0;
        va = ma >= 1 && ma <= 12;
        vb = mb >= 1 && mb <= 12;
        if (k == KIND_ADD)
        begin
            r.valid = va;
            if (!va)
            begin
                r.day = da; r.month = ma; r.year = ya;
            end
            else
            begin
                if (da == 0 && cnt == 0)
                begin
                    d = 0; m = ma; y = ya;
                end
                else
                begin
                    n = day_number(1, ma, ya) + da + cnt - 1;
                    q = n / 146097;
                    rem = n % 146097;
                    y = rem / 366;
                    while (days_to_year(y + 1) <= rem)
                        y++;
                    doy = rem - days_to_year(y);
                    m = 1;
                    while (m < 12 && doy >= month_length(m, y))
                    begin
                        doy -= month_length(m, y);
                        m++;
                    end
                    d = doy + 1;
                    y = y + 400 * q;
                end
                if (y > 9999)
                begin
                    r.day = 5'd31; r.month = 4'd12; r.year = 14'd9999; r.ovf = 1'b1;
                end
                else
                begin
                    r.day = 5'(d); r.month = 4'(m); r.year = 14'(y);
                end
            end
        end
        else
        begin
            r.valid = va && vb;
            if (va && vb)
            begin
                dd = day_number(da, ma, ya) - day_number(db, mb, yb);
                r.after = dd > 0;
                r.earlier = dd < 0;
                if (dd > 4194303) dd = 4194303;
                if (dd < -4194304) dd = -4194304;
                r.diff = 23'(dd);
            end
        end
        return r;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        errors++;
    endtask

    // sender: one transfer per call, random idle cycles before offering
    task automatic send_date(logic k, logic [4:0] da, logic [3:0] ma, logic [13:0] ya,
        logic [4:0] db, logic [3:0] mb, logic [13:0] yb, logic [19:0] cnt);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 0;
            @(posedge clk);
        end
        in_valid  <= 1;
        kind      <= k;
        day_a     <= da; month_a <= ma; year_a <= ya;
        day_b     <= db; month_b <= mb; year_b <= yb;
        add_count <= cnt;
        expected_dates.push_back(predict_date(k, da, ma, ya, db, mb, yb, cnt));
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    task automatic send_random;
        logic [3:0] ma, mb;
        ma = ($urandom_range(19) == 0) ? 4'($urandom_range(15)) : 4'($urandom_range(12, 1));
        mb = ($urandom_range(19) == 0) ? 4'($urandom_range(15)) : 4'($urandom_range(12, 1));
        send_date(1'($urandom_range(1)), 5'($urandom_range(31)), ma,
            ($urandom_range(3) == 0) ? 14'($urandom) : 14'($urandom_range(9999)),
            5'($urandom_range(31)), mb,
            ($urandom_range(3) == 0) ? 14'($urandom) : 14'($urandom_range(9999)),
            ($urandom_range(1) == 0) ? 20'($urandom_range(1000)) : 20'($urandom));
    endtask

    task automatic wait_drained;
        in_valid <= 0;
        while (expected_dates.size() != 0)
            @(posedge clk);
    endtask

    task automatic test_directed;
        send_date(KIND_ADD, 0, 1, 2000, 0, 0, 0, 0);
        send_date(KIND_ADD, 28, 2, 2000, 0, 0, 0, 1);
        send_date(KIND_ADD, 28, 2, 1900, 0, 0, 0, 1);
        send_date(KIND_ADD, 31, 12, 1999, 0, 0, 0, 1);
        send_date(KIND_ADD, 31, 12, 9999, 0, 0, 0, 1);
        send_date(KIND_ADD, 31, 15, 16383, 0, 0, 0, 20'hFFFFF);
        send_date(KIND_ADD, 5, 0, 3, 0, 0, 0, 7);
        send_date(KIND_ADD, 1, 1, 16383, 0, 0, 0, 0);
        send_date(KIND_ADD, 31, 12, 0, 0, 0, 0, 20'hFFFFF);
        send_date(KIND_ADD, 31, 2, 2001, 0, 0, 0, 0);
        send_date(KIND_DIFF, 1, 1, 1900, 1, 1, 1900, 0);
        send_date(KIND_DIFF, 1, 3, 2000, 28, 2, 2000, 0);
        send_date(KIND_DIFF, 1, 1, 0, 31, 12, 16383, 0);
        send_date(KIND_DIFF, 31, 12, 16383, 0, 1, 0, 0);
        send_date(KIND_DIFF, 1, 13, 2000, 1, 1, 2000, 0);
        send_date(KIND_DIFF, 1, 1, 2000, 1, 0, 2000, 0);
        send_date(KIND_DIFF, 31, 12, 9999, 1, 1, 0, 20'hFFFFF);
        wait_drained();
    endtask

    task automatic test_random(int count, int idle_pct, int stall_pct);
        send_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
        repeat (count)
            send_random();
        wait_drained();
    endtask

    // long receiver hold-off while sender keeps offering, then a full drain pause
    task automatic test_backpressure;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_off = 1;
        repeat (30)
            send_random();
        wait_drained();
        wait (!hold_off);
        repeat (20)
            send_random();
        wait_drained();
    endtask

    always @(posedge clk)
    begin
        if (!rst_n)
            out_ready <= 0;
        else if (hold_off)
            out_ready <= 0;
        else
            out_ready <= $urandom_range(99) >= recv_stall_pct;
    end

    initial
    begin
        int n;
        wait (hold_off);
        n = 0;
        while (n < 200)
        begin
            @(posedge clk);
            n++;
        end
        hold_off = 0;
    end

    // result checker
    always @(posedge clk)
    begin
        date_result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_dates.size() == 0)
            begin
                $display("unexpected result transfer at %0t", $realtime);
                errors++;
            end
            else
            begin
                want = expected_dates.pop_front();
                if (day_out !== want.day) report_mismatch("day_out", day_out, want.day);
                if (month_out !== want.month)
                    report_mismatch("month_out", month_out, want.month);
                if (year_out !== want.year) report_mismatch("year_out", year_out, want.year);
                if (day_difference !== want.diff)
                    report_mismatch("day_difference", day_difference, want.diff);
                if (a_after_b !== want.after)
                    report_mismatch("a_after_b", a_after_b, want.after);
                if (a_before_b !== want.earlier)
                    report_mismatch("a_before_b", a_before_b, want.earlier);
                if (dates_valid !== want.valid)
                    report_mismatch("dates_valid", dates_valid, want.valid);
                if (year_overflow !== want.ovf)
                    report_mismatch("year_overflow", year_overflow, want.ovf);
            end
        end
    end

    // watchdog on cycles with no transfer at all, outside the receiver hold-off
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || hold_off)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    initial
    begin
        rst_n = 0;
        in_valid = 0;
        kind = 0;
        day_a = 0; month_a = 0; year_a = 0;
        day_b = 0; month_b = 0; year_b = 0;
        add_count = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);
        test_directed();
        test_random(250, 0, 0);
        test_random(250, 79, 0);
        test_random(250, 0, 79);
        test_random(250, 34, 34);
        test_backpressure();
        repeat (GDA_STAGES + 20) @(posedge clk);
        if (errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end
endmodule
